FILE: hw/rtl/color_key_alpha_compositor_macros.svh
// ----------------------------------------------------------------------------
// Color key alpha compositor assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COLOR_KEY_ALPHA_COMPOSITOR_MACROS_SVH
`define COLOR_KEY_ALPHA_COMPOSITOR_MACROS_SVH

// Same-cycle implication
`define CKAC_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("%m: implication check failed");

// Next-cycle implication
`define CKAC_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("%m: next-cycle check failed");

`endif

FILE: hw/rtl/ckac_pkg.sv
// ----------------------------------------------------------------------------
// Color key alpha compositor package
// Register indexes, reset values, command codes and shared helpers.
// ----------------------------------------------------------------------------
package ckac_pkg;

    localparam int unsigned COLOR_W = 24;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned IDX_W   = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned PAL_DEPTH = 256;

    typedef logic [COLOR_W-1:0]   color_t;
    typedef logic [CHAN_W-1:0]    chan_t;
    typedef logic [2*CHAN_W-1:0]  prod_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Command codes
    localparam logic CMD_PIXEL   = 1'b0;
    localparam logic CMD_PALETTE = 1'b1;

    // Configuration register indexes
    localparam cfg_idx_t CFG_KEY_COLOR    = 3'd0;
    localparam cfg_idx_t CFG_BG_COLOR     = 3'd1;
    localparam cfg_idx_t CFG_INVERT_ALPHA = 3'd2;
    localparam cfg_idx_t CFG_BLEND_ENABLE = 3'd3;
    localparam cfg_idx_t CFG_USE_DELTA    = 3'd4;
    localparam cfg_idx_t CFG_USE_MASK     = 3'd5;

    // Reset values
    localparam color_t KEY_COLOR_RST = 24'hff0000;
    localparam color_t BG_COLOR_RST  = 24'hffffff;

    // Floor division by 255, exact for any 16-bit product of two bytes
    function automatic chan_t div255(input prod_t x);
        logic [2*CHAN_W:0] t;
        begin
            t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
            div255 = t[15:8];
        end
    endfunction

endpackage

FILE: hw/rtl/color_key_alpha_compositor.sv
// ----------------------------------------------------------------------------
// Color key alpha compositor
// Per-pixel color-key substitution and palette alpha blend over a background.
// ----------------------------------------------------------------------------
// One transaction is taken on every clock (busy stays low). A pixel transaction
// gives its result on done through the s1, s2 and done registers; a palette
// write gives none. The 256 x 24 alpha palette is a synchronous memory with a
// single write and a single read each cycle: a write is done at the taking
// edge and a read is launched at the taking edge, so a read may follow a write
// to the same slot in the very next cycle. The palette is not cleared after
// reset; a slot must be written before a pixel reads it. The receiver cannot
// stall: each result is on the ports for one cycle only. Configuration writes
// are taken at once (cfg_ready is high) and belong in idle periods.
// ----------------------------------------------------------------------------
`include "color_key_alpha_compositor_macros.svh"

module color_key_alpha_compositor
(
    input  logic                              clk,
    input  logic                              rst_n,
    // command channel
    input  logic                              start,
    output logic                              busy,
    input  logic                              cmd,
    input  logic [ckac_pkg::COLOR_W-1:0]      src_color,
    input  logic [ckac_pkg::COLOR_W-1:0]      delta_color,
    input  logic [ckac_pkg::IDX_W-1:0]        mask_index,
    input  logic [ckac_pkg::COLOR_W-1:0]      palette_entry,
    // result channel
    output logic                              done,
    output logic [ckac_pkg::COLOR_W-1:0]      out_color,
    output logic [ckac_pkg::CHAN_W-1:0]       out_alpha,
    output logic                              alpha_valid,
    // configuration channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ckac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ckac_pkg::COLOR_W-1:0]      cfg_data
);

    // Configuration registers
    ckac_pkg::color_t key_color_reg;
    ckac_pkg::color_t bg_color_reg;
    logic             invert_alpha_reg;
    logic             blend_enable_reg;
    logic             use_delta_reg;
    logic             use_mask_reg;

    // Palette memory and its registered read port
    ckac_pkg::color_t pal_mem [ckac_pkg::PAL_DEPTH];
    ckac_pkg::color_t rd_data_reg;

    // Pipeline registers
    logic             s1_vld_reg;
    ckac_pkg::color_t s1_color_reg;
    logic             s2_vld_reg;
    ckac_pkg::color_t s2_color_reg;
    ckac_pkg::chan_t  s2_alpha_b_reg;
    ckac_pkg::prod_t  s2_prod_c_reg [3];
    ckac_pkg::prod_t  s2_prod_b_reg [3];
    logic             done_reg;
    ckac_pkg::color_t out_color_reg;
    ckac_pkg::chan_t  out_alpha_reg;
    logic             alpha_valid_reg;

    logic             accept;
    logic             cfg_write;
    ckac_pkg::color_t key_color_sel;
    ckac_pkg::color_t alpha_use;
    ckac_pkg::prod_t  s2_prod_c_next [3];
    ckac_pkg::prod_t  s2_prod_b_next [3];
    ckac_pkg::color_t blend_color;
    ckac_pkg::color_t out_color_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign cfg_write = cfg_valid && cfg_ready;

    // Configuration writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_color_reg    <= ckac_pkg::KEY_COLOR_RST;
            bg_color_reg     <= ckac_pkg::BG_COLOR_RST;
            invert_alpha_reg <= 1'b1;
            blend_enable_reg <= 1'b1;
            use_delta_reg    <= 1'b0;
            use_mask_reg     <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ckac_pkg::CFG_KEY_COLOR:    key_color_reg    <= cfg_data;
                ckac_pkg::CFG_BG_COLOR:     bg_color_reg     <= cfg_data;
                ckac_pkg::CFG_INVERT_ALPHA: invert_alpha_reg <= cfg_data[0];
                ckac_pkg::CFG_BLEND_ENABLE: blend_enable_reg <= cfg_data[0];
                ckac_pkg::CFG_USE_DELTA:    use_delta_reg    <= cfg_data[0];
                ckac_pkg::CFG_USE_MASK:     use_mask_reg     <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    // Palette memory: write on palette command, read on every transaction
    always_ff @(posedge clk)
    begin
        if (accept && (cmd == ckac_pkg::CMD_PALETTE))
        begin
            pal_mem[mask_index] <= palette_entry;
        end
        if (accept)
        begin
            rd_data_reg <= pal_mem[mask_index];
        end
    end

    // Delta stage: key-colored delta pixels fall back to the source
    always_comb
    begin
        key_color_sel = src_color;
        if (use_delta_reg && (delta_color != key_color_reg))
        begin
            key_color_sel = delta_color;
        end
    end

    // Alpha select and per-channel products; the background weight is the
    // 8-bit complement of the alpha byte (255 - a)
    always_comb
    begin
        alpha_use = invert_alpha_reg ? ~rd_data_reg : rd_data_reg;
        for (int k = 0; k < 3; k++)
        begin
            s2_prod_c_next[k] = {8'd0, s1_color_reg[8*k +: 8]} * {8'd0, alpha_use[8*k +: 8]};
            s2_prod_b_next[k] = {8'd0, bg_color_reg[8*k +: 8]} * {8'd0, ~alpha_use[8*k +: 8]};
        end
    end

    // Divide each term by 255 and sum; the sum never exceeds 255
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            blend_color[8*k +: 8] = ckac_pkg::div255(s2_prod_c_reg[k])
                                  + ckac_pkg::div255(s2_prod_b_reg[k]);
        end
        out_color_next = (use_mask_reg && blend_enable_reg) ? blend_color : s2_color_reg;
    end

    // Valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= accept && (cmd == ckac_pkg::CMD_PIXEL);
            s2_vld_reg <= s1_vld_reg;
            done_reg   <= s2_vld_reg;
        end
    end

    // Payload pipeline
    always_ff @(posedge clk)
    begin
        s1_color_reg   <= key_color_sel;
        s2_color_reg   <= s1_color_reg;
        s2_alpha_b_reg <= alpha_use[7:0];
        for (int k = 0; k < 3; k++)
        begin
            s2_prod_c_reg[k] <= s2_prod_c_next[k];
            s2_prod_b_reg[k] <= s2_prod_b_next[k];
        end
        out_color_reg   <= out_color_next;
        out_alpha_reg   <= use_mask_reg ? s2_alpha_b_reg : 8'd0;
        alpha_valid_reg <= use_mask_reg;
    end

    assign done        = done_reg;
    assign out_color   = out_color_reg;
    assign out_alpha   = done_reg ? out_alpha_reg : 8'd0;
    assign alpha_valid = done_reg && alpha_valid_reg;

    // Checks
    `CKAC_ASSERT_NXT(a_pal_no_result, accept && (cmd == ckac_pkg::CMD_PALETTE), !s1_vld_reg)
    `CKAC_ASSERT_NXT(a_s1_to_s2, s1_vld_reg, s2_vld_reg)
    `CKAC_ASSERT_NXT(a_s2_to_done, s2_vld_reg, done_reg)
    `CKAC_ASSERT_IMP(a_no_mask_alpha, done_reg && !use_mask_reg, !alpha_valid && (out_alpha == 8'd0))

endmodule

FILE: sim/color_key_alpha_compositor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Color key alpha compositor testbench
// Drives pixel and palette-write transactions into the compositor and checks
// each result against a cycle-free predictor of the color-key, alpha mask and
// background blend. A directed part covers field and register extremes and
// every stage combination. Random phases follow, each with its own register
// setting; all but every third phase add random idle gaps on the command side.
// ----------------------------------------------------------------------------
module color_key_alpha_compositor_tb;

    import ckac_pkg::*;

    localparam int PIPE_LATENCY  = 3;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_ITEMS   = 110;
    localparam int REPORT_MAX    = 10;

    // Indexes past the end of the register list
    localparam cfg_idx_t CFG_SPARE_LO = 3'd6;
    localparam cfg_idx_t CFG_SPARE_HI = 3'd7;

    typedef logic [IDX_W-1:0] slot_t;

    typedef struct packed {
        color_t color;
        chan_t  alpha;
        logic   valid;
    } pixel_result_t;

    // DUT ports
    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    logic     busy;
    logic     cmd;
    color_t   src_color;
    color_t   delta_color;
    slot_t    mask_index;
    color_t   palette_entry;
    logic     done;
    color_t   out_color;
    chan_t    out_alpha;
    logic     alpha_valid;
    logic     cfg_valid;
    logic     cfg_ready;
    cfg_idx_t cfg_index;
    color_t   cfg_data;

    // Predictor state: registers and alpha palette
    color_t cur_key    = KEY_COLOR_RST;
    color_t cur_bg     = BG_COLOR_RST;
    logic   cur_invert = 1'b1;
    logic   cur_blend  = 1'b1;
    logic   cur_delta  = 1'b0;
    logic   cur_mask   = 1'b1;
    color_t alpha_table [PAL_DEPTH];
    bit     slot_written [PAL_DEPTH];
    slot_t  written_slots [$];
    slot_t  last_slot;

    pixel_result_t pending_results [$];
    int fail_count = 0;
    bit gaps_on = 1'b0;

    color_key_alpha_compositor uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .src_color     (src_color),
        .delta_color   (delta_color),
        .mask_index    (mask_index),
        .palette_entry (palette_entry),
        .done          (done),
        .out_color     (out_color),
        .out_alpha     (out_alpha),
        .alpha_valid   (alpha_valid),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic record_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Extremes of a 24-bit field half of the time, random otherwise
    function automatic color_t pick_color();
        int unsigned r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return 24'h000000;
        if (r == 1)
            return 24'hffffff;
        return color_t'($urandom);
    endfunction

    // Expected composite of one pixel from the current predictor state
    function automatic pixel_result_t composite_pixel(input color_t src, input color_t dlt,
                                                      input slot_t idx);
        pixel_result_t res;
        color_t        c;
        color_t        a;
        int unsigned   cc;
        int unsigned   aa;
        int unsigned   bb;
        int unsigned   mix;
        c = src;
        if (cur_delta && dlt != cur_key)
            c = dlt;
        res.alpha = '0;
        res.valid = 1'b0;
        if (cur_mask)
        begin
            a = alpha_table[idx];
            if (cur_invert)
                a = ~a;
            // per channel, each channel with its own alpha byte
            if (cur_blend)
                for (int k = 0; k < 3; k++)
                begin
                    cc  = c[8*k +: 8];
                    aa  = a[8*k +: 8];
                    bb  = cur_bg[8*k +: 8];
                    mix = (cc * aa) / 255 + (bb * (255 - aa)) / 255;
                    c[8*k +: 8] = mix[7:0];
                end
            res.alpha = a[7:0];
            res.valid = 1'b1;
        end
        res.color = c;
        return res;
    endfunction

    // One command transaction; the predictor is updated when it is taken
    task automatic send_item(input logic c, input color_t src, input color_t dlt,
                             input slot_t idx, input color_t ent);
        int unsigned r;
        int          gap;
        start         <= 1'b1;
        cmd           <= c;
        src_color     <= src;
        delta_color   <= dlt;
        mask_index    <= idx;
        palette_entry <= ent;
        do
            @(posedge clk);
        while (busy);
        if (c == CMD_PALETTE)
        begin
            alpha_table[idx] = ent;
            last_slot = idx;
            if (!slot_written[idx])
            begin
                slot_written[idx] = 1'b1;
                written_slots.push_back(idx);
            end
        end
        else
            pending_results.push_back(composite_pixel(src, dlt, idx));
        // idle gap: mostly none or short, now and then long
        gap = 0;
        if (gaps_on)
        begin
            r = $urandom_range(0, 99);
            if (r >= 92)
                gap = $urandom_range(8, 40);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Register write; cfg_valid is left high for a following write
    task automatic write_reg(input cfg_idx_t idx, input color_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_KEY_COLOR:    cur_key    = data;
            CFG_BG_COLOR:     cur_bg     = data;
            CFG_INVERT_ALPHA: cur_invert = data[0];
            CFG_BLEND_ENABLE: cur_blend  = data[0];
            CFG_USE_DELTA:    cur_delta  = data[0];
            CFG_USE_MASK:     cur_mask   = data[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input color_t key_val, input color_t bg_val,
                              input color_t inv_val, input color_t blend_val,
                              input color_t delta_val, input color_t mask_val);
        write_reg(CFG_KEY_COLOR, key_val);
        write_reg(CFG_BG_COLOR, bg_val);
        write_reg(CFG_INVERT_ALPHA, inv_val);
        write_reg(CFG_BLEND_ENABLE, blend_val);
        write_reg(CFG_USE_DELTA, delta_val);
        write_reg(CFG_USE_MASK, mask_val);
        cfg_valid <= 1'b0;
    endtask

    // Let every expected result arrive, then cover the pipeline once more
    task automatic wait_idle();
        int guard;
        start <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    // Reset register values, palette extremes, read right after write
    task automatic test_reset_defaults();
        send_item(CMD_PALETTE, 24'h000000, 24'h000000, 8'd0, 24'h000000);
        send_item(CMD_PALETTE, 24'hffffff, 24'hffffff, 8'd255, 24'hffffff);
        send_item(CMD_PALETTE, 24'h0f0f0f, 24'hf0f0f0, 8'd7, 24'h00ff80);
        send_item(CMD_PIXEL, 24'hffffff, 24'h000000, 8'd0, 24'hffffff);
        send_item(CMD_PIXEL, 24'h000000, 24'hffffff, 8'd255, 24'h000000);
        send_item(CMD_PIXEL, 24'h123456, 24'hff0000, 8'd7, 24'h5a5a5a);
        send_item(CMD_PALETTE, 24'h555555, 24'haaaaaa, 8'd9, 24'h0a0b0c);
        send_item(CMD_PIXEL, 24'habcdef, 24'h000001, 8'd9, 24'h800000);
        wait_idle();
    endtask

    // Stage combinations other than the mask stage alone, with key and background extremes
    task automatic test_stage_modes();
        // key match and no match, alpha used as written
        set_config(24'h000000, 24'h000000, 24'd0, 24'd1, 24'd1, 24'd1);
        send_item(CMD_PIXEL, 24'hff8040, 24'h000000, 8'd7, 24'h000000);
        send_item(CMD_PIXEL, 24'hff8040, 24'h00ff00, 8'd255, 24'h000000);
        wait_idle();
        // mask on with blend off
        set_config(24'hffffff, 24'hffffff, 24'd1, 24'd0, 24'd1, 24'd1);
        send_item(CMD_PIXEL, 24'h102030, 24'hffffff, 8'd7, 24'h000000);
        send_item(CMD_PIXEL, 24'h102030, 24'h010203, 8'd0, 24'h000000);
        wait_idle();
        // both stages off
        set_config(24'hff0000, 24'h808080, 24'd1, 24'd1, 24'd0, 24'd0);
        send_item(CMD_PIXEL, 24'h7f7f7f, 24'h123456, 8'd0, 24'h000000);
        wait_idle();
        // delta stage alone
        set_config(24'hff0000, 24'h808080, 24'd1, 24'd1, 24'd1, 24'd0);
        send_item(CMD_PIXEL, 24'h7f7f7f, 24'h123456, 8'd255, 24'h000000);
        wait_idle();
    endtask

    // Wide data on 1-bit registers and writes past the register list
    task automatic test_register_edges();
        write_reg(CFG_INVERT_ALPHA, 24'hfffffe);
        write_reg(CFG_USE_MASK, 24'hffff01);
        write_reg(CFG_BLEND_ENABLE, 24'h000003);
        write_reg(CFG_USE_DELTA, 24'h800000);
        write_reg(CFG_SPARE_LO, 24'hffffff);
        write_reg(CFG_SPARE_HI, 24'h000000);
        cfg_valid <= 1'b0;
        send_item(CMD_PIXEL, 24'h3c5a78, 24'hff0000, 8'd7, 24'h000000);
        send_item(CMD_PIXEL, 24'hc3a587, 24'h000000, 8'd9, 24'h000000);
        wait_idle();
    endtask

    // Random phases, each with a fresh register setting
    task automatic test_random_traffic();
        color_t src;
        color_t dlt;
        slot_t  idx;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_config(pick_color(), pick_color(), color_t'($urandom), color_t'($urandom),
                       color_t'($urandom), color_t'($urandom));
            gaps_on = (p % 3) != 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (written_slots.size() == 0 || $urandom_range(0, 3) == 0)
                begin
                    idx = slot_t'($urandom);
                    send_item(CMD_PALETTE, color_t'($urandom), color_t'($urandom), idx,
                              pick_color());
                end
                else
                begin
                    src = pick_color();
                    dlt = ($urandom_range(0, 99) < 35) ? cur_key : pick_color();
                    // often read the slot just written
                    if ($urandom_range(0, 4) == 0)
                        idx = last_slot;
                    else
                        idx = written_slots[$urandom_range(0, written_slots.size() - 1)];
                    send_item(CMD_PIXEL, src, dlt, idx, color_t'($urandom));
                end
            end
            wait_idle();
        end
    endtask

    // Result checker: compare each result with the oldest expectation
    always @(posedge clk)
    begin : result_check
        pixel_result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_results.size() == 0)
                record_failure($sformatf("unexpected result: color %h alpha %h valid %b",
                                         out_color, out_alpha, alpha_valid));
            else
            begin
                want = pending_results.pop_front();
                if (out_color !== want.color)
                    record_failure($sformatf("out_color: expected %h, got %h",
                                             want.color, out_color));
                if (out_alpha !== want.alpha)
                    record_failure($sformatf("out_alpha: expected %h, got %h",
                                             want.alpha, out_alpha));
                if (alpha_valid !== want.valid)
                    record_failure($sformatf("alpha_valid: expected %b, got %b",
                                             want.valid, alpha_valid));
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n         <= 1'b0;
        start         <= 1'b0;
        cmd           <= CMD_PIXEL;
        src_color     <= '0;
        delta_color   <= '0;
        mask_index    <= '0;
        palette_entry <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_KEY_COLOR;
        cfg_data      <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_stage_modes();
        test_register_edges();
        test_random_traffic();

        wait_idle();
        if (pending_results.size() != 0)
            record_failure($sformatf("%0d results never arrived", pending_results.size()));
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
